>>> hw/rtl/pida_pkg.sv
// shared types and codes for the positional insert/delete array
// no dependencies
`timescale 1ns / 1ps

package pida_pkg;

	localparam int WordW = 32;

	typedef enum logic [1:0] {
		CMD_CLEAR   = 2'd0,
		CMD_INSERT  = 2'd1,
		CMD_DELETE  = 2'd2,
		CMD_DISPLAY = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		EDIT_NONE   = 2'd0,
		EDIT_CLEAR  = 2'd1,
		EDIT_INSERT = 2'd2,
		EDIT_DELETE = 2'd3
	} edit_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_DISP = 1'b1
	} state_t;

	// controller to datapath
	typedef struct packed {
		edit_t   edit;
		logic    rd_pos;
		logic    rd_idx;
		logic    idx_load;
		logic    idx_inc;
		logic    out_load;
		status_t out_status;
		logic    out_use_rd;
		logic    out_last_rd;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
		logic ins_bad;
		logic del_bad;
		logic rd_last;
	} dp_stat_t;

endpackage

>>> hw/rtl/pida_ctrl.sv
// controller state machine for the positional insert/delete array
// depends on pida_pkg
`timescale 1ns / 1ps

module pida_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         cmd,
	input  pida_pkg::dp_stat_t stat,
	output pida_pkg::dp_cmd_t  ctl,
	output logic               busy
);
	import pida_pkg::*;

	state_t state_q;
	state_t state_d;
	cmd_t   cmd_c;

	assign cmd_c = cmd_t'(cmd);
	assign busy  = (state_q == S_DISP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		ctl             = '0;
		ctl.edit        = EDIT_NONE;
		ctl.out_status  = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.out_load = 1'b1;
					unique case (cmd_c)
						CMD_CLEAR: begin
							ctl.edit = EDIT_CLEAR;
						end
						CMD_INSERT: begin
							if (stat.full) begin
								ctl.out_status = ST_FULL;
							end else if (stat.ins_bad) begin
								ctl.out_status = ST_BADPOS;
							end else begin
								ctl.edit = EDIT_INSERT;
							end
						end
						CMD_DELETE: begin
							ctl.rd_pos = 1'b1;
							if (stat.empty) begin
								ctl.out_status = ST_EMPTY;
							end else if (stat.del_bad) begin
								ctl.out_status = ST_BADPOS;
							end else begin
								ctl.edit       = EDIT_DELETE;
								ctl.out_use_rd = 1'b1;
							end
						end
						CMD_DISPLAY: begin
							if (stat.empty) begin
								ctl.out_status = ST_EMPTY;
							end else begin
								// first entry goes out now, rest from the walk
								ctl.out_use_rd  = 1'b1;
								ctl.out_last_rd = 1'b1;
								if (!stat.rd_last) begin
									ctl.idx_load = 1'b1;
									state_d      = S_DISP;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_DISP: begin
				ctl.rd_idx      = 1'b1;
				ctl.idx_inc     = 1'b1;
				ctl.out_load    = 1'b1;
				ctl.out_use_rd  = 1'b1;
				ctl.out_last_rd = 1'b1;
				if (stat.rd_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_no_edit_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DISP) |-> (ctl.edit == EDIT_NONE))
		else $error("list edited during display walk");

	a_walk_ends_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DISP && stat.rd_last) |=> (state_q == S_IDLE))
		else $error("display walk did not end after last entry");

endmodule

>>> hw/rtl/pida_dp.sv
// datapath for the positional insert/delete array: entry cells, count,
// display index and result registers; depends on pida_pkg
`timescale 1ns / 1ps

module pida_dp #(
	parameter int DEPTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pida_pkg::dp_cmd_t   ctl,
	input  logic [4:0]          position,
	input  logic signed [31:0]  value,
	output pida_pkg::dp_stat_t  stat,
	output logic                done,
	output logic [1:0]          status,
	output logic signed [31:0]  data,
	output logic                last
);
	import pida_pkg::*;

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > 5) ? CW : 5;

	logic signed [WordW-1:0] entry_q [DEPTH];
	logic [CW-1:0]           count_q;
	logic [AW-1:0]           idx_q;
	logic [AW-1:0]           rd_addr;
	logic signed [WordW-1:0] rd_data;
	logic [CMPW-1:0]         pos_c;
	logic [CMPW-1:0]         cnt_c;
	logic                    done_q;
	status_t                 status_q;
	logic signed [WordW-1:0] data_q;
	logic                    last_q;

	assign pos_c = CMPW'(position);
	assign cnt_c = CMPW'(count_q);

	always_comb begin
		if (ctl.rd_idx) begin
			rd_addr = idx_q;
		end else if (ctl.rd_pos) begin
			rd_addr = AW'(position);
		end else begin
			rd_addr = '0;
		end
	end

	assign rd_data = entry_q[rd_addr];

	assign stat.empty   = (count_q == '0);
	assign stat.full    = (count_q == CW'(DEPTH));
	assign stat.ins_bad = (pos_c > cnt_c);
	assign stat.del_bad = (pos_c >= cnt_c);
	assign stat.rd_last = ((CW'(rd_addr) + CW'(1)) == count_q);

	// each cell takes its own word, a neighbor or the new value
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CMPW-1:0] Idx = CMPW'(i);
		always_ff @(posedge clk) begin
			if (ctl.edit == EDIT_INSERT) begin
				if (Idx == pos_c) begin
					entry_q[i] <= value;
				end else if (Idx > pos_c) begin
					entry_q[i] <= entry_q[(i > 0) ? i - 1 : 0];
				end
			end else if (ctl.edit == EDIT_DELETE) begin
				if (Idx >= pos_c && i < DEPTH - 1) begin
					entry_q[i] <= entry_q[(i < DEPTH - 1) ? i + 1 : i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= ctl.out_load;
			case (ctl.edit)
				EDIT_CLEAR:  count_q <= '0;
				EDIT_INSERT: count_q <= count_q + CW'(1);
				EDIT_DELETE: count_q <= count_q - CW'(1);
				default:     count_q <= count_q;
			endcase
			if (ctl.idx_load) begin
				idx_q <= AW'(1);
			end else if (ctl.idx_inc) begin
				idx_q <= idx_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			status_q <= ctl.out_status;
			data_q   <= ctl.out_use_rd ? rd_data : '0;
			last_q   <= ctl.out_last_rd ? stat.rd_last : 1'b1;
		end
	end

	assign done   = done_q;
	assign status = status_q;
	assign data   = data_q;
	assign last   = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond depth");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.edit == EDIT_INSERT) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the count");

	a_delete_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.edit == EDIT_DELETE) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("delete did not shrink the count");

endmodule

>>> hw/rtl/positional_insert_delete_array.sv
// the first result strobe of an accepted request comes in the cycle after it
// clear, insert and delete give one result each;
// a request may follow every cycle for those
// display of n entries gives n results on consecutive cycles, busy while the
// entries after the first are read; the entry read mux sets one entry per cycle
// reset clears the count and control; stored words are undefined until written
`timescale 1ns / 1ps

module positional_insert_delete_array_core #(
	parameter int DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         cmd,
	input  logic [4:0]         position,
	input  logic signed [31:0] value,
	output logic               done,
	output logic [1:0]         status,
	output logic signed [31:0] data,
	output logic               last
);
	import pida_pkg::*;

	dp_cmd_t  ctl;
	dp_stat_t stat;

	pida_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy)
	);

	pida_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.position (position),
		.value    (value),
		.stat     (stat),
		.done     (done),
		.status   (status),
		.data     (data),
		.last     (last)
	);

endmodule

>>> test/testbench.sv
// self-checking bench for positional_insert_delete_array_core
// depends on pida_pkg for command and status codes; needs only the rtl
`timescale 1ns / 1ps

module testbench;
	import pida_pkg::*;

	localparam int LIST_DEPTH = 32;

	typedef struct {
		status_t            status;
		logic signed [31:0] data;
		logic               last;
	} list_result_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         cmd;
	logic [4:0]         position;
	logic signed [31:0] value;
	logic               done;
	logic [1:0]         status;
	logic signed [31:0] data;
	logic               last;

	// shadow copy of the list
	logic signed [31:0] shadow_words [LIST_DEPTH];
	int                 shadow_count;
	list_result_t       pending_results [$];

	int error_count;
	int burst_left;
	bit gaps_on;

	positional_insert_delete_array_core #(
		.DEPTH(LIST_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.position(position),
		.value(value),
		.done(done),
		.status(status),
		.data(data),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic void push_pending(status_t st, logic signed [31:0] d, logic l);
		list_result_t r;
		r.status = st;
		r.data   = d;
		r.last   = l;
		pending_results.push_back(r);
	endfunction

	// apply one accepted request to the shadow list and queue its results
	function automatic void predict_list_outcome(cmd_t c, logic [4:0] p, logic signed [31:0] v);
		int i;
		case (c)
			CMD_CLEAR: begin
				shadow_count = 0;
				push_pending(ST_OK, 32'sd0, 1'b1);
			end
			CMD_INSERT: begin
				if (shadow_count >= LIST_DEPTH) begin
					push_pending(ST_FULL, 32'sd0, 1'b1);
				end else if (int'(p) > shadow_count) begin
					push_pending(ST_BADPOS, 32'sd0, 1'b1);
				end else begin
					for (i = shadow_count; i > int'(p); i--)
						shadow_words[i] = shadow_words[i - 1];
					shadow_words[p] = v;
					shadow_count++;
					push_pending(ST_OK, 32'sd0, 1'b1);
				end
			end
			CMD_DELETE: begin
				if (shadow_count == 0) begin
					push_pending(ST_EMPTY, 32'sd0, 1'b1);
				end else if (int'(p) >= shadow_count) begin
					push_pending(ST_BADPOS, 32'sd0, 1'b1);
				end else begin
					push_pending(ST_OK, shadow_words[p], 1'b1);
					for (i = int'(p); i + 1 < shadow_count; i++)
						shadow_words[i] = shadow_words[i + 1];
					shadow_count--;
				end
			end
			default: begin
				if (shadow_count == 0) begin
					push_pending(ST_EMPTY, 32'sd0, 1'b1);
				end else begin
					for (i = 0; i < shadow_count; i++)
						push_pending(ST_OK, shadow_words[i], (i + 1 == shadow_count));
				end
			end
		endcase
	endfunction

	// one request; start stays high between back-to-back requests
	task automatic send_request(cmd_t c, logic [4:0] p, logic signed [31:0] v);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gaps_on) begin
				gap = $urandom_range(1, 6);
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start    <= 1'b1;
		cmd      <= c;
		position <= p;
		value    <= v;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		predict_list_outcome(c, p, v);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic test_empty_list();
		send_request(CMD_DISPLAY, 5'd0, 32'sd0);
		send_request(CMD_DELETE, 5'd0, 32'sd0);
		send_request(CMD_DELETE, 5'd31, 32'sd0);
		send_request(CMD_INSERT, 5'd1, 32'sd5);
		send_request(CMD_CLEAR, 5'd31, -32'sd1);
		send_request(CMD_DISPLAY, 5'd31, -32'sd1);
	endtask

	task automatic test_directed_edits();
		send_request(CMD_INSERT, 5'd0, 32'sh7FFF_FFFF);
		send_request(CMD_INSERT, 5'd2, 32'sd7);
		send_request(CMD_INSERT, 5'd1, 32'sh8000_0000);
		send_request(CMD_INSERT, 5'd1, 32'sd0);
		send_request(CMD_INSERT, 5'd0, -32'sd1);
		send_request(CMD_DISPLAY, 5'd0, 32'sd0);
		send_request(CMD_DELETE, 5'd31, 32'sd0);
		send_request(CMD_DELETE, 5'd4, 32'sd0);
		send_request(CMD_DELETE, 5'd3, 32'sd0);
		send_request(CMD_DELETE, 5'd1, 32'sd0);
		send_request(CMD_DELETE, 5'd0, 32'sd0);
		send_request(CMD_DISPLAY, 5'd0, 32'sd0);
		send_request(CMD_DELETE, 5'd0, 32'sd0);
		send_request(CMD_DISPLAY, 5'd0, 32'sd0);
		send_request(CMD_CLEAR, 5'd0, 32'sd0);
	endtask

	// fill to the top, then full and position checks at the boundary
	task automatic test_full_list();
		int j;
		send_request(CMD_CLEAR, 5'd0, 32'sd0);
		for (j = 0; j < LIST_DEPTH; j++)
			send_request(CMD_INSERT, 5'($urandom_range(0, j)), $urandom());
		send_request(CMD_INSERT, 5'd31, $urandom());
		send_request(CMD_INSERT, 5'd0, $urandom());
		send_request(CMD_DISPLAY, 5'd0, 32'sd0);
		send_request(CMD_DELETE, 5'd31, 32'sd0);
		send_request(CMD_DELETE, 5'd31, 32'sd0);
		send_request(CMD_INSERT, 5'd31, 32'sh8000_0000);
		send_request(CMD_DELETE, 5'd0, 32'sd0);
	endtask

	task automatic test_random_traffic(int target);
		int sent;
		int roll;
		int k;
		int j;
		bit want_delete;
		sent = 0;
		while (sent < target) begin
			if ($urandom_range(0, 59) == 0)
				gaps_on = ~gaps_on;
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				send_request(cmd_t'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
					$urandom());
				sent++;
			end else if (roll < 11) begin
				// load: clear then appends
				k = ($urandom_range(0, 7) == 0) ? LIST_DEPTH : $urandom_range(0, 12);
				send_request(CMD_CLEAR, 5'($urandom_range(0, 31)), $urandom());
				for (j = 0; j < k; j++)
					send_request(CMD_INSERT, 5'(shadow_count), $urandom());
				sent += k + 1;
			end else if (roll < 14) begin
				if (shadow_count < LIST_DEPTH - 1 && $urandom_range(0, 1) == 0)
					send_request(CMD_INSERT, 5'($urandom_range(shadow_count + 1, 31)),
						$urandom());
				else if (shadow_count < LIST_DEPTH)
					send_request(CMD_DELETE, 5'($urandom_range(shadow_count, 31)),
						$urandom());
				else
					send_request(CMD_INSERT, 5'($urandom_range(0, 31)), $urandom());
				sent++;
			end else if (roll < 22) begin
				send_request(CMD_DISPLAY, 5'($urandom_range(0, 31)), $urandom());
				sent++;
			end else if (roll < 24) begin
				send_request(CMD_CLEAR, 5'($urandom_range(0, 31)), $urandom());
				sent++;
			end else begin
				if (shadow_count == 0)
					want_delete = 1'b0;
				else if (shadow_count > 24)
					want_delete = ($urandom_range(0, 99) < 70);
				else
					want_delete = ($urandom_range(0, 99) < 40);
				if (want_delete)
					send_request(CMD_DELETE, 5'($urandom_range(0, shadow_count - 1)),
						$urandom());
				else if (shadow_count < LIST_DEPTH)
					send_request(CMD_INSERT, 5'($urandom_range(0, shadow_count)),
						$urandom());
				else
					send_request(CMD_INSERT, 5'($urandom_range(0, 31)), $urandom());
				sent++;
			end
			if ($urandom_range(0, 149) == 0)
				drain_results();
		end
	endtask

	// result checker; the receiver cannot stall, every strobe is consumed
	always @(posedge clk) begin
		list_result_t exp_r;
		if (arst_n === 1'b1 && done !== 1'b0) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result status %0d data %0d last %0b",
					$time, status, data, last);
				error_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, exp_r.status, status);
					error_count++;
				end
				if (data !== exp_r.data) begin
					$display("%0t: data expected %0d actual %0d", $time, exp_r.data, data);
					error_count++;
				end
				if (last !== exp_r.last) begin
					$display("%0t: last expected %0b actual %0b", $time, exp_r.last, last);
					error_count++;
				end
			end
		end
	end

	initial begin
		int waited;
		error_count  = 0;
		shadow_count = 0;
		burst_left   = 0;
		gaps_on      = 1'b1;
		arst_n   = 1'b0;
		start    = 1'b0;
		cmd      = CMD_CLEAR;
		position = 5'd0;
		value    = 32'sd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_directed_edits();
		drain_results();
		test_full_list();
		test_random_traffic(370);
		drain_results();

		waited = 0;
		while (pending_results.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_results.size());
			error_count += pending_results.size();
		end
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
